// ----- design/utf8_stream_decoder_macros.svh -----
// Assertion macros shared by the decoder modules.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define UTF8SD_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define UTF8SD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define UTF8SD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/utf8sd_pkg.sv -----
// Package for the UTF-8 stream decoder: byte range constants, result and
// queue entry types, and queue sizing. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package utf8sd_pkg;

  localparam int unsigned CP_W = 21;

  localparam logic [7:0] BYTE_ASCII_END = 8'h80;
  localparam logic [7:0] LEAD2_LO       = 8'hC2;
  localparam logic [7:0] LEAD2_HI       = 8'hDF;
  localparam logic [7:0] LEAD3_LO       = 8'hE0;
  localparam logic [7:0] LEAD3_HI       = 8'hEF;
  localparam logic [7:0] LEAD4_LO       = 8'hF0;
  localparam logic [7:0] LEAD4_HI       = 8'hF4;
  localparam logic [7:0] LEAD_ED        = 8'hED;
  localparam logic [7:0] CONT_LO        = 8'h80;
  localparam logic [7:0] CONT_HI        = 8'hBF;
  localparam logic [7:0] CONT_LO_E0     = 8'hA0;
  localparam logic [7:0] CONT_HI_ED     = 8'h9F;
  localparam logic [7:0] CONT_LO_F0     = 8'h90;
  localparam logic [7:0] CONT_HI_F4     = 8'h8F;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            bad;
  } result_t;

  // One queue entry holds every result caused by one input byte.
  typedef struct packed {
    logic    two;
    result_t res0;
    result_t res1;
  } entry_t;

  localparam result_t BAD_RESULT = '{code_point: '0, bad: 1'b1};

endpackage

`default_nettype wire

// ----- design/utf8sd_if.sv -----
// Handshake interfaces for the decoder's byte input and result output.
// The output interface depends on utf8sd_pkg for the code point width.
`timescale 1ns / 1ps
`default_nettype none

interface utf8sd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface utf8sd_out_if
  import utf8sd_pkg::*;
  ;
  logic            valid;
  logic            ready;
  logic [CP_W-1:0] code_point;
  logic            bad;
  logic            last_of_run;

  modport source (output valid, output code_point, output bad, output last_of_run,
                  input ready);
  modport sink (input valid, input code_point, input bad, input last_of_run,
                output ready);
endinterface

`default_nettype wire

// ----- design/utf8_stream_decoder.sv -----
// UTF-8 stream decoder. Bytes enter on in_ch with an end-of-input flag, and
// decoded scalar values or bad marks for ill-formed subparts leave on out_ch,
// each with last_of_run set on the final result of the byte that caused it.
// The decoder accepts one byte per cycle while the queue has room; a byte
// that closes a sequence, passes ASCII or is rejected yields one result, a
// byte inside a sequence yields none unless it ends the input, and a byte
// that breaks a sequence may yield two, each in its own output transfer. A
// four-entry queue between the byte front end and the output register absorbs
// these bursts, so the input only stalls when the output is held back or
// two-result bytes arrive faster than the output can drain them. With the queue
// empty, a result passes through a queue slot and then the output register.
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_decoder
  import utf8sd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  utf8sd_in_if.sink     in_ch,
  utf8sd_out_if.source  out_ch
);

  logic   q_push;
  entry_t q_entry;
  logic   q_pop;
  logic   q_full;
  logic   q_not_empty;
  entry_t q_head;

  utf8sd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_entry)
  );

  utf8sd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  utf8sd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_ch      (out_ch)
  );

endmodule

`default_nettype wire

// ----- design/utf8sd_front.sv -----
// Front end: accepts bytes, tracks the open sequence and forms the results of
// each byte as one queue entry. Depends on utf8sd_pkg, utf8sd_if and the macros.
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_stream_decoder_macros.svh"

module utf8sd_front
  import utf8sd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  utf8sd_in_if.sink    in_ch,
  input  wire logic    q_full,
  output logic         q_push,
  output entry_t       q_entry
);

  logic [1:0]      rem_r, rem_nxt;
  logic [CP_W-1:0] part_r, part_nxt;
  logic [7:0]      lo_r, lo_nxt;
  logic [7:0]      hi_r, hi_nxt;

  logic [7:0]      b;
  logic            eoi;
  logic            acc;
  logic            in_range;
  logic            cont;
  logic            brk;
  logic            complete;
  logic            is_ascii, is_2, is_3, is_4, is_inv;
  logic            lead_put;
  logic            open_after;
  logic            eoi_bad;
  logic [CP_W-1:0] shifted;
  result_t         lead_res;
  result_t         done_res;

  assign b   = in_ch.in_byte;
  assign eoi = in_ch.end_of_input;
  assign in_ch.ready = !q_full;
  assign acc = in_ch.valid && !q_full;

  assign in_range = (b >= lo_r) && (b <= hi_r);
  assign cont     = (rem_r != 2'd0) && in_range;
  assign brk      = (rem_r != 2'd0) && !in_range;
  assign complete = cont && (rem_r == 2'd1);
  assign shifted  = {part_r[CP_W-7:0], b[5:0]};

  assign is_ascii = b < BYTE_ASCII_END;
  assign is_2     = (b >= LEAD2_LO) && (b <= LEAD2_HI);
  assign is_3     = (b >= LEAD3_LO) && (b <= LEAD3_HI);
  assign is_4     = (b >= LEAD4_LO) && (b <= LEAD4_HI);
  assign is_inv   = !(is_ascii || is_2 || is_3 || is_4);

  assign lead_put   = !cont && (is_ascii || is_inv);
  assign open_after = cont ? (rem_r != 2'd1) : (is_2 || is_3 || is_4);
  assign eoi_bad    = eoi && open_after;

  assign lead_res = is_ascii ? result_t'{code_point: {{(CP_W-8){1'b0}}, b}, bad: 1'b0}
                             : BAD_RESULT;
  assign done_res = '{code_point: shifted, bad: 1'b0};

  always_comb begin
    q_entry.two  = brk && (lead_put || eoi_bad);
    q_entry.res0 = brk ? BAD_RESULT :
                   complete ? done_res :
                   lead_put ? lead_res : BAD_RESULT;
    q_entry.res1 = lead_put ? lead_res : BAD_RESULT;
    q_push       = acc && (brk || complete || lead_put || eoi_bad);
  end

  always_comb begin
    rem_nxt  = rem_r;
    part_nxt = part_r;
    lo_nxt   = lo_r;
    hi_nxt   = hi_r;
    if (acc) begin
      lo_nxt = CONT_LO;
      hi_nxt = CONT_HI;
      if (cont) begin
        rem_nxt  = rem_r - 2'd1;
        part_nxt = complete ? '0 : shifted;
      end else if (is_2) begin
        rem_nxt  = 2'd1;
        part_nxt = {{(CP_W-5){1'b0}}, b[4:0]};
      end else if (is_3) begin
        rem_nxt  = 2'd2;
        part_nxt = {{(CP_W-4){1'b0}}, b[3:0]};
        if (b == LEAD3_LO) begin
          lo_nxt = CONT_LO_E0;
        end else if (b == LEAD_ED) begin
          hi_nxt = CONT_HI_ED;
        end
      end else if (is_4) begin
        rem_nxt  = 2'd3;
        part_nxt = {{(CP_W-3){1'b0}}, b[2:0]};
        if (b == LEAD4_LO) begin
          lo_nxt = CONT_LO_F0;
        end else if (b == LEAD4_HI) begin
          hi_nxt = CONT_HI_F4;
        end
      end else begin
        rem_nxt  = 2'd0;
        part_nxt = '0;
      end
      if (eoi_bad) begin
        rem_nxt  = 2'd0;
        part_nxt = '0;
        lo_nxt   = CONT_LO;
        hi_nxt   = CONT_HI;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= 2'd0;
      part_r <= '0;
      lo_r   <= CONT_LO;
      hi_r   <= CONT_HI;
    end else begin
      rem_r  <= rem_nxt;
      part_r <= part_nxt;
      lo_r   <= lo_nxt;
      hi_r   <= hi_nxt;
    end
  end

  // With no sequence open the gathered bits and bounds are at their idle values.
  `UTF8SD_ASSERT_IMP(a_idle_state, rem_r == 2'd0,
    (part_r == '0) && (lo_r == CONT_LO) && (hi_r == CONT_HI), "idle state not clear")
  `UTF8SD_ASSERT_NXT(a_eoi_closes, acc && eoi, rem_r == 2'd0, "sequence open after end")
  `UTF8SD_ASSERT_IMP(a_two_needs_brk, q_push && q_entry.two, q_entry.res0.bad,
    "second result without a leading bad mark")

endmodule

`default_nettype wire

// ----- design/utf8sd_queue.sv -----
// Short queue of result entries between the front and back ends.
// Depends on utf8sd_pkg and the assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_stream_decoder_macros.svh"

module utf8sd_queue
  import utf8sd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire entry_t push_entry,
  input  wire logic   pop,
  output logic        full,
  output logic        not_empty,
  output entry_t      head
);

  entry_t            slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt;
  logic [QPTR_W-1:0] rd_r, rd_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = cnt_r == QCNT_W'(QDEPTH);
  assign not_empty = cnt_r != '0;
  assign head      = slot_r[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  `UTF8SD_ASSERT(a_cnt_bound, cnt_r <= QCNT_W'(QDEPTH), "queue count beyond depth")

endmodule

`default_nettype wire

// ----- design/utf8sd_back.sv -----
// Back end: takes queue entries and presents their results one transaction at
// a time through an output register. Depends on utf8sd_pkg, utf8sd_if, macros.
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_stream_decoder_macros.svh"

module utf8sd_back
  import utf8sd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   q_not_empty,
  input  wire entry_t q_head,
  output logic        q_pop,
  utf8sd_out_if.source out_ch
);

  logic            vld_r, vld_nxt;
  logic            second_r, second_nxt;
  result_t         res_r, res_nxt;
  logic            last_r, last_nxt;
  logic            load;

  assign load = !vld_r || out_ch.ready;

  always_comb begin
    vld_nxt    = vld_r;
    second_nxt = second_r;
    res_nxt    = res_r;
    last_nxt   = last_r;
    q_pop      = 1'b0;
    if (load) begin
      vld_nxt = q_not_empty;
      if (q_not_empty) begin
        if (!second_r) begin
          res_nxt    = q_head.res0;
          last_nxt   = !q_head.two;
          second_nxt = q_head.two;
          q_pop      = !q_head.two;
        end else begin
          res_nxt    = q_head.res1;
          last_nxt   = 1'b1;
          second_nxt = 1'b0;
          q_pop      = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= 1'b0;
      second_r <= 1'b0;
    end else begin
      vld_r    <= vld_nxt;
      second_r <= second_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r  <= res_nxt;
    last_r <= last_nxt;
  end

  assign out_ch.valid       = vld_r;
  assign out_ch.code_point  = res_r.code_point;
  assign out_ch.bad         = res_r.bad;
  assign out_ch.last_of_run = last_r;

  // The second half of an entry is only pending while that entry still heads the queue.
  `UTF8SD_ASSERT_IMP(a_second_has_head, second_r, q_not_empty && vld_r,
    "second result pending without its entry")

endmodule

`default_nettype wire
